// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the priority ready queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define PRQ_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PRQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRQ_ASSERT(name, clk, rst_n, prop)
`define PRQ_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define PRQ_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/prq_pkg.sv -----
// constants and types of the priority ready queue
package prq_pkg;

  localparam int unsigned QUEUE_DEPTH   = 64;
  localparam int unsigned PRIORITY_BITS = 6;
  localparam int unsigned ID_BITS       = 8;

  localparam int unsigned ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_W = ID_BITS + PRIORITY_BITS;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REPRIO = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_EMPTY  = 2'd2,
    STATUS_ABSENT = 2'd3
  } status_e;

endpackage

// ----- rtl/core/prq_ram.sv -----
// generic simple dual port ram with registered read
module prq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/priority_ready_queue.sv -----
// Priority ready queue of thread ids, descending priority, first in first out among equals.
// The input channel (in_valid_i / in_ready_o) carries one operation item: insert, pop or
// reprioritize. The output channel (out_valid_o / out_ready_i) returns exactly one result
// item per operation: status, the popped id and priority, and the entry count afterwards.
// Entries sit sorted in one ram with one write and one registered read port; a small
// sequencer walks the ram entry by entry, reading an entry, then comparing and moving it.
// Full, empty pop, unused opcode, insert into empty and reprioritize on empty are answered
// straight from the idle state. Insert reads from the tail and slides each entry of lower
// priority one place toward the tail, then writes the new entry into the gap. Pop reads
// and returns the head, then moves every later entry one place toward the head.
// Reprioritize searches from the head for the id and answers absent if it is not there;
// else it removes the entry in the same way and inserts it anew with the new priority.
// One item is in work at a time and in_ready_o is low meanwhile, so the next item can be
// accepted in the cycle after the result enters the output register. A finished result
// waits in the output register while the next item may be accepted; a stalled receiver
// holds off the item after that, whose finished result waits in the sequencer until the
// output register frees.
// Reset empties the queue at once by clearing the count; ram contents are not cleared.
module priority_ready_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] thread_id_i,
  input  logic [5:0] priority_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] picked_id_o,
  output logic [5:0] picked_priority_o,
  output logic [6:0] queue_count_o
);
  import prq_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_INS_PUT,
    S_POP_RD,
    S_POP_CHK,
    S_DROP_RD,
    S_DROP_WR,
    S_FIND_RD,
    S_FIND_CHK,
    S_HOLD
  } state_e;

  state_e                   state_q, state_d;
  logic [COUNT_W-1:0]       count_q, count_d;
  logic [COUNT_W-1:0]       idx_q, idx_d;
  logic                     out_valid_q, out_valid_d;
  logic [1:0]               op_q, op_d;
  logic [ID_BITS-1:0]       id_q, id_d;
  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  status_e                  status_q, status_d;
  logic [ID_BITS-1:0]       picked_id_q, picked_id_d;
  logic [PRIORITY_BITS-1:0] picked_prio_q, picked_prio_d;
  status_e                  out_status_q, out_status_d;
  logic [ID_BITS-1:0]       out_id_q, out_id_d;
  logic [PRIORITY_BITS-1:0] out_prio_q, out_prio_d;
  logic [COUNT_W-1:0]       out_count_q, out_count_d;

  logic                     in_fire;
  logic                     item_done;
  logic [ID_BITS-1:0]       id_in;
  logic [PRIORITY_BITS-1:0] prio_in;
  logic [COUNT_W-1:0]       idx_m1, idx_p1;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic [ID_BITS-1:0]       rd_id;
  logic [PRIORITY_BITS-1:0] rd_prio;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign id_in      = ID_BITS'(thread_id_i);
  assign prio_in    = PRIORITY_BITS'(priority_req_i);
  assign idx_m1     = idx_q - COUNT_W'(1);
  assign idx_p1     = idx_q + COUNT_W'(1);
  assign rd_id      = ram_rdata[ENTRY_W-1:PRIORITY_BITS];
  assign rd_prio    = ram_rdata[PRIORITY_BITS-1:0];

  prq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    op_d          = op_q;
    id_d          = id_q;
    prio_d        = prio_q;
    status_d      = status_q;
    picked_id_d   = picked_id_q;
    picked_prio_d = picked_prio_q;
    out_status_d  = out_status_q;
    out_id_d      = out_id_q;
    out_prio_d    = out_prio_q;
    out_count_d   = out_count_q;
    item_done     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_q[ADDR_W-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_q[ADDR_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d          = opcode_i;
          id_d          = id_in;
          prio_d        = prio_in;
          status_d      = STATUS_DONE;
          picked_id_d   = '0;
          picked_prio_d = '0;
          case (opcode_i)
            OP_INSERT: begin
              if (count_q == COUNT_W'(QUEUE_DEPTH)) begin
                status_d  = STATUS_FULL;
                item_done = 1'b1;
              end else if (count_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {id_in, prio_in};
                count_d   = COUNT_W'(1);
                item_done = 1'b1;
              end else begin
                idx_d   = count_q;
                state_d = S_INS_RD;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d  = STATUS_EMPTY;
                item_done = 1'b1;
              end else begin
                state_d = S_POP_RD;
              end
            end
            OP_REPRIO: begin
              if (count_q == '0) begin
                status_d  = STATUS_ABSENT;
                item_done = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_FIND_RD;
              end
            end
            default: begin
              item_done = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        ram_raddr = idx_m1[ADDR_W-1:0];
        state_d   = S_INS_CHK;
      end
      S_INS_CHK: begin
        // lower priority entries slide one place toward the tail
        if (rd_prio < prio_q) begin
          ram_we  = 1'b1;
          idx_d   = idx_m1;
          state_d = (idx_m1 == '0) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = {id_q, prio_q};
        count_d   = count_q + COUNT_W'(1);
        item_done = 1'b1;
        state_d   = S_IDLE;
      end
      S_POP_RD: begin
        ram_raddr = '0;
        state_d   = S_POP_CHK;
      end
      S_POP_CHK: begin
        picked_id_d   = rd_id;
        picked_prio_d = rd_prio;
        idx_d         = COUNT_W'(1);
        state_d       = S_DROP_RD;
      end
      S_DROP_RD: begin
        if (idx_q == count_q) begin
          count_d = count_q - COUNT_W'(1);
          if (op_q == OP_REPRIO) begin
            idx_d   = count_q - COUNT_W'(1);
            state_d = (count_q == COUNT_W'(1)) ? S_INS_PUT : S_INS_RD;
          end else begin
            item_done = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          state_d = S_DROP_WR;
        end
      end
      S_DROP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[ADDR_W-1:0];
        idx_d     = idx_p1;
        state_d   = S_DROP_RD;
      end
      S_FIND_RD: begin
        state_d = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (rd_id == id_q) begin
          idx_d   = idx_p1;
          state_d = S_DROP_RD;
        end else if (idx_p1 == count_q) begin
          status_d  = STATUS_ABSENT;
          item_done = 1'b1;
          state_d   = S_IDLE;
        end else begin
          idx_d   = idx_p1;
          state_d = S_FIND_RD;
        end
      end
      S_HOLD: begin
        item_done = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // a finished result waits here while the output register is still taken
    if (item_done) begin
      if (out_valid_d) begin
        state_d = S_HOLD;
      end else begin
        out_valid_d  = 1'b1;
        out_status_d = status_d;
        out_id_d     = picked_id_d;
        out_prio_d   = picked_prio_d;
        out_count_d  = count_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    id_q          <= id_d;
    prio_q        <= prio_d;
    status_q      <= status_d;
    picked_id_q   <= picked_id_d;
    picked_prio_q <= picked_prio_d;
    out_status_q  <= out_status_d;
    out_id_q      <= out_id_d;
    out_prio_q    <= out_prio_d;
    out_count_q   <= out_count_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign picked_id_o       = 8'(out_id_q);
  assign picked_priority_o = 6'(out_prio_q);
  assign queue_count_o     = 7'(out_count_q);

  `PRQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= COUNT_W'(QUEUE_DEPTH))
  `PRQ_ASSERT(a_count_step, clk_i, rst_ni, COUNT_W'(count_d - count_q + COUNT_W'(1)) <= 2)
  `PRQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q)
  `PRQ_ASSERT_IMPL(a_hold_full, clk_i, rst_ni, state_q == S_HOLD, out_valid_q)
  `PRQ_ASSERT_IMPL(a_write_busy, clk_i, rst_ni, ram_we, (state_q != S_IDLE) || in_fire)

endmodule
